// ===== rtl/mfre_pkg.sv =====
// Shared types and codes for the matrix flip/rotate engine.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package mfre_pkg;

  localparam int unsigned MAX_DIM_DEF = 128;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CNT_W-1:0] RESET_ROWS = 8'd4;
  localparam logic [CNT_W-1:0] RESET_COLS = 8'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  // request types
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_APPLY = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // apply operations
  localparam logic [2:0] OP_VFLIP    = 3'd1;
  localparam logic [2:0] OP_HFLIP    = 3'd2;
  localparam logic [2:0] OP_ROT_R    = 3'd3;
  localparam logic [2:0] OP_ROT_L    = 3'd4;
  localparam logic [2:0] OP_QUAD_CW  = 3'd5;
  localparam logic [2:0] OP_QUAD_CCW = 3'd6;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] elem_value;
    logic [2:0]               op_code;
  } req_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] read_value;
    logic [CNT_W-1:0]         rows_now;
    logic [CNT_W-1:0]         cols_now;
    logic                     index_error;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PASS1,
    ST_MID,
    ST_PASS2,
    ST_LAST
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/mfre_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mfre_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/matrix_flip_rotate_engine_unit.sv =====
// Matrix flip/rotate engine top level: control, address generation, two RAMs.
// Depends on mfre_pkg and mfre_ram.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start_i is high and busy_o is low; its response
// appears on rsp_o for one cycle with done_o high and must be taken then.
// Write and non-matrix requests answer in the cycle after acceptance; reads
// answer after a pass through ST_READ. An apply runs two sweeps through the
// RAMs, one element per cycle: the matrix is read and each element written
// to its new place in a scratch RAM, then the scratch region is copied back,
// with ST_MID between the sweeps and ST_LAST after them. Applies with a zero
// count or an unknown operation answer in the cycle after acceptance.
module matrix_flip_rotate_engine_unit #(
  parameter int unsigned MAX_DIM = mfre_pkg::MAX_DIM_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire mfre_pkg::req_t                      req_i,
  output logic                                     done_o,
  output mfre_pkg::rsp_t                           rsp_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [mfre_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mfre_pkg::CNT_W-1:0]          cfg_data_i
);

  import mfre_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] cell_addr(logic [CNT_W-1:0] r, logic [CNT_W-1:0] c);
    logic [AW+CNT_W-1:0] full;
    full = (AW+CNT_W)'(r) * (AW+CNT_W)'(MAX_DIM) + (AW+CNT_W)'(c);
    return full[AW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_dim(logic [CNT_W-1:0] v);
    logic [CNT_W:0] lim;
    lim = (CNT_W+1)'(MAX_DIM);
    return ({1'b0, v} > lim) ? lim[CNT_W-1:0] : v;
  endfunction

  state_e state_q, state_d;

  logic [CNT_W-1:0] row_cfg_q, col_cfg_q;
  logic [CNT_W-1:0] rows_q, cols_q, rows_d, cols_d;
  logic [CNT_W-1:0] ri_q, ci_q, ri_d, ci_d;
  logic [2:0]       op_q;
  logic             rd_err_q;
  logic             wv_q, wp2_q;
  logic [AW-1:0]    wa_q;
  logic             done_q;
  rsp_t             rsp_q;

  logic             accept;
  logic             in_range;
  logic             apply_ok;
  logic             last_cell;
  logic [CNT_W-1:0] new_rows, new_cols;
  logic [CNT_W-1:0] dr, dc;

  logic [AW-1:0]     mat_raddr, mat_waddr;
  logic [ELEM_W-1:0] mat_wdata, mat_rdata, scr_rdata;
  logic              mat_we;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign new_rows = sat_dim(row_cfg_q);
  assign new_cols = sat_dim(col_cfg_q);

  always_comb begin
    if (req_i.req_type == REQ_WRITE) begin
      in_range = ({1'b0, req_i.row_index} < new_rows) && ({1'b0, req_i.col_index} < new_cols);
    end else begin
      in_range = ({1'b0, req_i.row_index} < rows_q) && ({1'b0, req_i.col_index} < cols_q);
    end
  end

  assign apply_ok  = (rows_q != '0) && (cols_q != '0) &&
                     (req_i.op_code inside {[OP_VFLIP:OP_QUAD_CCW]});
  assign last_cell = (ri_q == rows_q - 8'd1) && (ci_q == cols_q - 8'd1);

  // destination of element (ri_q, ci_q) in the first sweep
  always_comb begin
    logic [CNT_W-1:0] h, w;
    logic top, bot, lft, rgt;
    h   = rows_q >> 1;
    w   = cols_q >> 1;
    top = ri_q < h;
    bot = (ri_q >= h) && (ri_q < {h[CNT_W-2:0], 1'b0});
    lft = ci_q < w;
    rgt = (ci_q >= w) && (ci_q < {w[CNT_W-2:0], 1'b0});
    dr  = ri_q;
    dc  = ci_q;
    case (op_q)
      OP_VFLIP: dr = rows_q - 8'd1 - ri_q;
      OP_HFLIP: dc = cols_q - 8'd1 - ci_q;
      OP_ROT_R: begin
        dr = ci_q;
        dc = rows_q - 8'd1 - ri_q;
      end
      OP_ROT_L: begin
        dr = cols_q - 8'd1 - ci_q;
        dc = ri_q;
      end
      OP_QUAD_CW: begin
        if (bot && lft) dr = ri_q - h;
        else if (bot && rgt) dc = ci_q - w;
        else if (top && rgt) dr = ri_q + h;
        else if (top && lft) dc = ci_q + w;
      end
      OP_QUAD_CCW: begin
        if (top && rgt) dc = ci_q - w;
        else if (bot && rgt) dr = ri_q - h;
        else if (bot && lft) dc = ci_q + w;
        else if (top && lft) dr = ri_q + h;
      end
      default: ;
    endcase
  end

  // next state, sweep counters and matrix dimensions
  always_comb begin
    state_d = state_q;
    ri_d    = ri_q;
    ci_d    = ci_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ri_d = '0;
          ci_d = '0;
          case (req_i.req_type)
            REQ_WRITE: begin
              rows_d = new_rows;
              cols_d = new_cols;
            end
            REQ_APPLY: if (apply_ok) state_d = ST_PASS1;
            REQ_READ:  state_d = ST_READ;
            default: ;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_PASS1, ST_PASS2: begin
        if (last_cell) begin
          ri_d    = '0;
          ci_d    = '0;
          state_d = (state_q == ST_PASS1) ? ST_MID : ST_LAST;
          if (state_q == ST_PASS1 && (op_q == OP_ROT_R || op_q == OP_ROT_L)) begin
            rows_d = cols_q;
            cols_d = rows_q;
          end
        end else if (ci_q == cols_q - 8'd1) begin
          ci_d = '0;
          ri_d = ri_q + 8'd1;
        end else begin
          ci_d = ci_q + 8'd1;
        end
      end
      ST_MID:  state_d = ST_PASS2;   // last scratch write lands before copy-back reads
      ST_LAST: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_cfg_q <= RESET_ROWS;
      col_cfg_q <= RESET_COLS;
      rows_q    <= RESET_ROWS;
      cols_q    <= RESET_COLS;
      ri_q      <= '0;
      ci_q      <= '0;
      wv_q      <= 1'b0;
      wp2_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      ri_q    <= ri_d;
      ci_q    <= ci_d;
      wv_q    <= (state_q == ST_PASS1) || (state_q == ST_PASS2);
      wp2_q   <= (state_q == ST_PASS2);
      done_q  <= (accept && !(req_i.req_type == REQ_READ) &&
                  !(req_i.req_type == REQ_APPLY && apply_ok)) ||
                 (state_q == ST_READ) || (state_q == ST_LAST);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_COUNT: row_cfg_q <= cfg_data_i;
          CFG_COL_COUNT: col_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.op_code;
      rd_err_q <= !in_range;
    end
    wa_q <= (state_q == ST_PASS1) ? cell_addr(dr, dc) : cell_addr(ri_q, ci_q);
    rsp_q.rows_now <= rows_d;
    rsp_q.cols_now <= cols_d;
    if (state_q == ST_READ) begin
      rsp_q.read_value  <= rd_err_q ? '0 : signed'(mat_rdata);
      rsp_q.index_error <= rd_err_q;
    end else begin
      rsp_q.read_value  <= '0;
      rsp_q.index_error <= accept && (req_i.req_type == REQ_WRITE) && !in_range;
    end
  end

  // matrix RAM ports: direct access when idle, sweep otherwise
  assign mat_raddr = (state_q == ST_IDLE) ?
                     cell_addr({1'b0, req_i.row_index}, {1'b0, req_i.col_index}) :
                     cell_addr(ri_q, ci_q);
  assign mat_we    = (wv_q && wp2_q) ||
                     (accept && (req_i.req_type == REQ_WRITE) && in_range);
  assign mat_waddr = (state_q == ST_IDLE) ?
                     cell_addr({1'b0, req_i.row_index}, {1'b0, req_i.col_index}) : wa_q;
  assign mat_wdata = (state_q == ST_IDLE) ? ELEM_W'(req_i.elem_value) : scr_rdata;

  mfre_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_matrix_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  mfre_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_scratch_ram (
    .clk_i   (clk_i),
    .we_i    (wv_q && !wp2_q),
    .waddr_i (wa_q),
    .wdata_i (mat_rdata),
    .raddr_i (cell_addr(ri_q, ci_q)),
    .rdata_o (scr_rdata)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire
